FILE: rtl/oopt_pkg.sv
// Shared types, constants and helpers for the on-off persistence sketch.
package oopt_pkg;

  localparam int COUNT_W      = 32;
  localparam int OP_W         = 2;
  localparam int ROW_W        = 10;
  localparam int KEY_W        = 64;
  localparam int ROWS_DEF     = 1024;
  localparam int BUCKETS_DEF  = 8;
  localparam int KEY_BITS_DEF = 64;

  typedef logic [OP_W-1:0]    op_t;
  typedef logic [COUNT_W-1:0] count_t;

  localparam op_t OP_INSERT = 2'd0;
  localparam op_t OP_QUERY  = 2'd1;
  localparam op_t OP_EOW    = 2'd2;
  localparam op_t OP_NOP    = 2'd3;

  // Query answer handed from the row update logic to the top level
  typedef struct packed {
    count_t estimate;
    logic   in_slot;
  } upd_res_t;

  // Saturating increment
  function automatic count_t sat_inc(input count_t v);
    count_t r;
    r = (v == '1) ? v : v + count_t'(1);
    return r;
  endfunction

endpackage

FILE: rtl/oopt_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface oopt_in_if;
  logic                         valid;
  logic                         ready;
  oopt_pkg::op_t                op;
  logic [oopt_pkg::ROW_W-1:0]   row;
  logic [oopt_pkg::KEY_W-1:0]   item_key;

  modport source (output valid, output op, output row, output item_key, input ready);
  modport sink   (input valid, input op, input row, input item_key, output ready);
endinterface

interface oopt_out_if;
  logic             valid;
  logic             ready;
  oopt_pkg::count_t estimate;
  logic             in_slot;

  modport source (output valid, output estimate, output in_slot, input ready);
  modport sink   (input valid, input estimate, input in_slot, output ready);
endinterface

FILE: rtl/oopt_mem.sv
// Row memory: one write port, one read port, registered read data.
module oopt_mem #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/oopt_upd.sv
// Row update: key match, least-count search and slot swap on one row word.
module oopt_upd #(
  parameter int BUCKETS  = 8,
  parameter int KEY_BITS = 64,
  parameter int SLOT_W   = KEY_BITS + 34,
  parameter int CTR_W    = 33,
  parameter int WORD_W   = CTR_W + BUCKETS * SLOT_W
) (
  input  oopt_pkg::op_t      op,
  input  logic [KEY_BITS-1:0] key,
  input  logic [WORD_W-1:0]  rdata,
  output logic [WORD_W-1:0]  wdata,
  output oopt_pkg::upd_res_t res
);
  import oopt_pkg::*;

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

  logic [KEY_BITS-1:0] skey [BUCKETS];
  count_t              scnt [BUCKETS];
  logic                son  [BUCKETS];
  logic                sval [BUCKETS];
  count_t              rc_cnt;
  logic                rc_on;

  // Unpack the row word
  assign rc_cnt = rdata[COUNT_W-1:0];
  assign rc_on  = rdata[COUNT_W];
  for (genvar g = 0; g < BUCKETS; g++) begin : g_unpack
    assign skey[g] = rdata[CTR_W + g*SLOT_W +: KEY_BITS];
    assign scnt[g] = rdata[CTR_W + g*SLOT_W + KEY_BITS +: COUNT_W];
    assign son[g]  = rdata[CTR_W + g*SLOT_W + KEY_BITS + COUNT_W];
    assign sval[g] = rdata[CTR_W + g*SLOT_W + KEY_BITS + COUNT_W + 1];
  end

  logic                hit;
  logic [BW-1:0]       hidx;
  logic [BW-1:0]       midx;
  count_t              mcnt;
  count_t              c_cnt;
  logic                c_on;
  logic [KEY_BITS-1:0] nkey [BUCKETS];
  count_t              ncnt [BUCKETS];
  logic                non  [BUCKETS];
  logic                nval [BUCKETS];

  always_comb begin
    // First valid match, first least count
    hit  = 1'b0;
    hidx = '0;
    midx = '0;
    mcnt = scnt[0];
    for (int b = 0; b < BUCKETS; b++) begin
      if (!hit && sval[b] && skey[b] == key) begin
        hit  = 1'b1;
        hidx = BW'(b);
      end
    end
    for (int b = 1; b < BUCKETS; b++) begin
      if (scnt[b] < mcnt) begin
        mcnt = scnt[b];
        midx = BW'(b);
      end
    end

    for (int b = 0; b < BUCKETS; b++) begin
      nkey[b] = skey[b];
      ncnt[b] = scnt[b];
      non[b]  = son[b];
      nval[b] = sval[b];
    end
    c_cnt = rc_cnt;
    c_on  = rc_on;

    if (op == OP_INSERT) begin
      if (hit) begin
        if (!son[hidx]) begin
          ncnt[hidx] = sat_inc(scnt[hidx]);
          non[hidx]  = 1'b1;
        end
      end else begin
        if (!rc_on) begin
          c_cnt = sat_inc(rc_cnt);
          c_on  = 1'b1;
        end
        // Promote the key when the row counter caught up with the weakest slot
        if (c_cnt >= mcnt) begin
          nkey[midx] = key;
          nval[midx] = 1'b1;
          ncnt[midx] = c_cnt;
          non[midx]  = c_on;
          c_cnt      = mcnt;
          c_on       = son[midx];
        end
      end
    end

    wdata[COUNT_W-1:0] = c_cnt;
    wdata[COUNT_W]     = c_on;
    for (int b = 0; b < BUCKETS; b++) begin
      wdata[CTR_W + b*SLOT_W +: SLOT_W] = {nval[b], non[b], ncnt[b], nkey[b]};
    end

    res.estimate = hit ? scnt[hidx] : rc_cnt;
    res.in_slot  = hit;
  end

endmodule

FILE: rtl/onoff_persistence_topk.sv
// Top level of the on-off persistence sketch with per-row top-k slots.
//
// Input channel in_ch carries op (insert, query, end of window, unused code),
// a precomputed row index and the item key. Result channel out_ch carries one
// beat per query: the estimate and whether it came from a keyed slot.
// Each row (shared counter plus BUCKETS slots) is one word of a single
// synchronous memory. An insert or query reads the row in the accept cycle,
// then does match, minimum search and, for an insert, write back in ST_EXEC.
// A row index at or above ROWS first passes through ST_RED: it is reduced
// modulo ROWS by compare-and-subtract steps, the high half registered in
// row_r, the low half applied to that to form the read address. The unused
// code is taken and dropped. End of window sweeps the memory clearing every
// on flag, one row a cycle overlapped with its read, with in_ch.ready low.
// After reset the same sweep writes zero to every row before the first beat
// is taken.
// The result sits in an output register; while it waits, inserts still run,
// and a following query holds in its final step until out_ch is taken.
module onoff_persistence_topk #(
  parameter int ROWS     = oopt_pkg::ROWS_DEF,
  parameter int BUCKETS  = oopt_pkg::BUCKETS_DEF,
  parameter int KEY_BITS = oopt_pkg::KEY_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  oopt_in_if.sink    in_ch,
  oopt_out_if.source out_ch
);
  import oopt_pkg::*;

  localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SLOT_W = KEY_BITS + COUNT_W + 2;
  localparam int CTR_W  = COUNT_W + 1;
  localparam int WORD_W = CTR_W + BUCKETS * SLOT_W;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RED   = 2'd2;
  localparam logic [1:0] ST_EXEC  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  logic [RW:0]         cnt_r, cnt_nxt;
  logic                wipe_r, wipe_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic                red_half_r, red_half_nxt;
  op_t                 op_r, op_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;
  logic [RW-1:0]       addr_r, addr_nxt;
  logic                out_valid_r, out_valid_nxt;
  count_t              est_r, est_nxt;
  logic                in_slot_r, in_slot_nxt;

  logic                mem_we, mem_re;
  logic [RW-1:0]       mem_waddr, mem_raddr;
  logic [WORD_W-1:0]   mem_wdata, mem_rdata, upd_wdata, clr_word;
  upd_res_t            upd_res;
  logic [ROW_W-1:0]    row_lo;

  // Restoring compare-and-subtract of ROWS << k for k from khi down to klo
  function automatic logic [ROW_W-1:0] reduce_row(input logic [ROW_W-1:0] v,
                                                  input int khi, input int klo);
    logic [ROW_W-1:0] t;
    t = v;
    for (int k = khi; k >= klo; k--) begin
      if ((ROWS << k) < (1 << ROW_W)) begin
        if (32'(t) >= (ROWS << k)) begin
          t = t - ROW_W'(ROWS << k);
        end
      end
    end
    return t;
  endfunction

  // Low half of the row reduction, on the row already reduced by the high half
  assign row_lo = reduce_row(row_r, ROW_W/2 - 1, 0);

  oopt_mem #(.DEPTH(ROWS), .WIDTH(WORD_W), .AW(RW)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  oopt_upd #(.BUCKETS(BUCKETS), .KEY_BITS(KEY_BITS), .SLOT_W(SLOT_W), .CTR_W(CTR_W),
             .WORD_W(WORD_W)) u_upd (
    .op    (op_r),
    .key   (key_r),
    .rdata (mem_rdata),
    .wdata (upd_wdata),
    .res   (upd_res)
  );

  // Row word with every on flag cleared, for the end-of-window sweep
  always_comb begin
    clr_word          = mem_rdata;
    clr_word[COUNT_W] = 1'b0;
    for (int b = 0; b < BUCKETS; b++) begin
      clr_word[CTR_W + b*SLOT_W + KEY_BITS + COUNT_W] = 1'b0;
    end
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.estimate = est_r;
  assign out_ch.in_slot  = in_slot_r;

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    wipe_nxt      = wipe_r;
    row_nxt       = row_r;
    red_half_nxt  = red_half_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    est_nxt       = est_r;
    in_slot_nxt   = in_slot_r;
    mem_we        = 1'b0;
    mem_waddr     = addr_r;
    mem_wdata     = upd_wdata;
    mem_re        = 1'b0;
    mem_raddr     = addr_r;

    case (state_r)
      ST_SWEEP: begin
        // Read row cnt, write back row cnt-1
        mem_re    = (32'(cnt_r) < ROWS);
        mem_raddr = cnt_r[RW-1:0];
        mem_we    = (cnt_r != '0);
        mem_waddr = RW'(cnt_r - 1'b1);
        mem_wdata = wipe_r ? '0 : clr_word;
        cnt_nxt   = cnt_r + 1'b1;
        if (32'(cnt_r) == ROWS) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_ch.valid) begin
          op_nxt  = in_ch.op;
          key_nxt = in_ch.item_key[KEY_BITS-1:0];
          row_nxt = in_ch.row;
          if (in_ch.op == OP_EOW) begin
            state_nxt = ST_SWEEP;
            cnt_nxt   = '0;
            wipe_nxt  = 1'b0;
          end else if (in_ch.op == OP_INSERT || in_ch.op == OP_QUERY) begin
            if (32'(in_ch.row) < ROWS) begin
              mem_re    = 1'b1;
              mem_raddr = RW'(in_ch.row);
              addr_nxt  = RW'(in_ch.row);
              state_nxt = ST_EXEC;
            end else begin
              red_half_nxt = 1'b0;
              state_nxt    = ST_RED;
            end
          end
        end
      end
      ST_RED: begin
        // Row index reduced modulo ROWS, high steps then low steps
        if (!red_half_r) begin
          row_nxt      = reduce_row(row_r, ROW_W - 1, ROW_W/2);
          red_half_nxt = 1'b1;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = RW'(row_lo);
          addr_nxt  = RW'(row_lo);
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (op_r == OP_QUERY) begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_nxt = 1'b1;
            est_nxt       = upd_res.estimate;
            in_slot_nxt   = upd_res.in_slot;
            state_nxt     = ST_IDLE;
          end
        end else begin
          mem_we    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cnt_r       <= '0;
      wipe_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      wipe_r      <= wipe_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    row_r      <= row_nxt;
    red_half_r <= red_half_nxt;
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    addr_r     <= addr_nxt;
    est_r      <= est_nxt;
    in_slot_r  <= in_slot_nxt;
  end

  // A result appears only out of the final step of a query
  a_out_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_EXEC) && $past(op_r == OP_QUERY))
    else $error("result beat without a query step");

  // No row write while beats are being taken
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != ST_IDLE))
    else $error("row memory written in idle");

  // An end-of-window beat always starts a sweep
  a_eow_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.op == OP_EOW) |=> (state_r == ST_SWEEP) && !wipe_r)
    else $error("end of window did not start the on-flag sweep");

endmodule

FILE: dv/onoff_persistence_topk_test.sv
// Self-checking testbench for the on-off persistence sketch with top-k slots.
`timescale 1ns / 1ps

module onoff_persistence_topk_test;
  import oopt_pkg::*;

  localparam int NROWS = ROWS_DEF;
  localparam int NBUCK = BUCKETS_DEF;
  localparam int NSLOT = NROWS * NBUCK;
  localparam logic [31:0] CMAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] estimate;
    logic        in_slot;
  } answer_t;

  typedef struct {
    op_t         op;
    logic [9:0]  row;
    logic [63:0] key;
    bit          fixed;   // expected answer typed in
    answer_t     ans;
  } stim_t;

  logic clk;
  logic rst_n;
  oopt_in_if  in_ch ();
  oopt_out_if out_ch ();

  onoff_persistence_topk dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Shadow sketch state
  logic [31:0] ctr_count [NROWS];
  bit          ctr_on    [NROWS];
  logic [63:0] sl_key    [NSLOT];
  logic [31:0] sl_count  [NSLOT];
  bit          sl_on     [NSLOT];
  bit          sl_valid  [NSLOT];

  answer_t pending_answers[$];
  int      errors;
  int      send_idle_pct;
  int      recv_stall_pct;
  stim_t   directed[$];

  function automatic logic [31:0] bump(logic [31:0] v);
    return (v == CMAX) ? v : v + 32'd1;
  endfunction

  // Apply one beat to the shadow sketch; returns 1 with an answer for a query
  function automatic bit sketch_apply(op_t op, logic [9:0] row_in, logic [63:0] key,
                                      output answer_t ans);
    int r, base, hit, m;
    logic [31:0] tc;
    bit to;
    r = int'(row_in) % NROWS;
    base = r * NBUCK;
    hit = -1;
    ans = '0;
    for (int b = 0; b < NBUCK; b++)
      if (hit < 0 && sl_valid[base+b] && sl_key[base+b] == key) hit = base + b;
    case (op)
      OP_INSERT: begin
        if (hit >= 0) begin
          if (!sl_on[hit]) begin
            sl_count[hit] = bump(sl_count[hit]);
            sl_on[hit] = 1;
          end
        end else begin
          if (!ctr_on[r]) begin
            ctr_count[r] = bump(ctr_count[r]);
            ctr_on[r] = 1;
          end
          m = base;
          for (int b = 1; b < NBUCK; b++)
            if (sl_count[base+b] < sl_count[m]) m = base + b;
          if (ctr_count[r] >= sl_count[m]) begin
            tc = sl_count[m];
            to = sl_on[m];
            sl_key[m] = key;
            sl_valid[m] = 1;
            sl_count[m] = ctr_count[r];
            sl_on[m] = ctr_on[r];
            ctr_count[r] = tc;
            ctr_on[r] = to;
          end
        end
        return 0;
      end
      OP_QUERY: begin
        if (hit >= 0) ans = '{sl_count[hit], 1'b1};
        else ans = '{ctr_count[r], 1'b0};
        return 1;
      end
      OP_EOW: begin
        for (int i = 0; i < NROWS; i++) ctr_on[i] = 0;
        for (int i = 0; i < NSLOT; i++) sl_on[i] = 0;
        return 0;
      end
      default: return 0;
    endcase
  endfunction

  // Clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Run limit
  initial begin
    #400ms;
    $display("FAILURE");
    $finish;
  end

  // Drive one beat at the falling edge, hold until accepted
  task automatic send_beat(op_t op, logic [9:0] row, logic [63:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.op       <= op;
    in_ch.row      <= row;
    in_ch.item_key <= key;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic issue(op_t op, logic [9:0] row, logic [63:0] key, bit fixed, answer_t want);
    answer_t a;
    if (sketch_apply(op, row, key, a)) begin
      if (fixed && a != want) begin
        $display("%0t directed answer mismatch: expected %h actual %h", $time, want, a);
        errors++;
      end
      pending_answers.push_back(a);
    end
    send_beat(op, row, key);
  endtask

  task automatic drain;
    int guard;
    guard = 0;
    in_ch.valid <= 1'b0;
    while (pending_answers.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (pending_answers.size() != 0) begin
      $display("FAILURE");
      $finish;
    end
    repeat (NROWS + 10) @(posedge clk);
    @(negedge clk);
  endtask

  // Receiver backpressure
  always @(negedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Result checker
  always @(posedge clk) begin
    answer_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.estimate, out_ch.in_slot};
      if (pending_answers.size() == 0) begin
        $display("%0t unexpected beat: expected none actual %h", $time, got);
        errors++;
      end else begin
        want = pending_answers.pop_front();
        if (got.estimate !== want.estimate) begin
          $display("%0t estimate mismatch: expected %h actual %h", $time,
                   want.estimate, got.estimate);
          errors++;
        end
        if (got.in_slot !== want.in_slot) begin
          $display("%0t in_slot mismatch: expected %b actual %b", $time,
                   want.in_slot, got.in_slot);
          errors++;
        end
      end
    end
  end

  function automatic stim_t row_of(op_t op, logic [9:0] row, logic [63:0] key,
                                   bit fixed, logic [31:0] est, logic slot);
    stim_t s;
    s.op = op; s.row = row; s.key = key; s.fixed = fixed; s.ans = '{est, slot};
    return s;
  endfunction

  // Random key, mostly from a small shared pool, so hits and evictions happen
  function automatic logic [63:0] pick_key();
    if ($urandom_range(9) == 0) return {$urandom, $urandom};
    return {$urandom_range(1) ? 32'hFFFF_FFFF : 32'h0, 28'h0, 4'($urandom_range(11))};
  endfunction

  initial begin
    stim_t s;
    answer_t dummy;
    int phase, n, k;
    op_t op;
    logic [9:0] row;
    errors = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    for (int i = 0; i < NROWS; i++) begin ctr_count[i] = 0; ctr_on[i] = 0; end
    for (int i = 0; i < NSLOT; i++) begin
      sl_key[i] = 0; sl_count[i] = 0; sl_on[i] = 0; sl_valid[i] = 0;
    end
    in_ch.valid = 0; in_ch.op = OP_NOP; in_ch.row = 0; in_ch.item_key = 0;
    out_ch.ready = 0;
    rst_n = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed table: fresh-state answers, extremes, every opcode
    directed.push_back(row_of(OP_QUERY, 10'd0, 64'h0, 1, 32'd0, 1'b0));
    directed.push_back(row_of(OP_QUERY, 10'h3FF, '1, 1, 32'd0, 1'b0));
    directed.push_back(row_of(OP_INSERT, 10'd0, 64'h0, 0, 0, 0));
    directed.push_back(row_of(OP_QUERY, 10'd0, 64'h0, 1, 32'd1, 1'b1));
    directed.push_back(row_of(OP_INSERT, 10'd0, 64'h0, 0, 0, 0));
    directed.push_back(row_of(OP_QUERY, 10'd0, 64'h0, 1, 32'd1, 1'b1));
    directed.push_back(row_of(OP_INSERT, 10'h3FF, '1, 0, 0, 0));
    directed.push_back(row_of(OP_QUERY, 10'h3FF, '1, 1, 32'd1, 1'b1));
    directed.push_back(row_of(OP_NOP, 10'h155, 64'hAAAA_5555_AAAA_5555, 0, 0, 0));
    directed.push_back(row_of(OP_QUERY, 10'h3FF, 64'h7, 0, 0, 0));
    directed.push_back(row_of(OP_EOW, 10'h2AA, 64'h5555_AAAA_5555_AAAA, 0, 0, 0));
    directed.push_back(row_of(OP_INSERT, 10'd0, 64'h0, 0, 0, 0));
    directed.push_back(row_of(OP_QUERY, 10'd0, 64'h0, 1, 32'd2, 1'b1));
    for (int i = 1; i <= 9; i++)
      directed.push_back(row_of(OP_INSERT, 10'd5, 64'(i), 0, 0, 0));
    directed.push_back(row_of(OP_QUERY, 10'd5, 64'd9, 0, 0, 0));
    directed.push_back(row_of(OP_QUERY, 10'd5, 64'd1, 0, 0, 0));
    foreach (directed[i]) begin
      s = directed[i];
      issue(s.op, s.row, s.key, s.fixed, s.ans);
    end
    drain();

    // Random phases with different idle/stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      n = 0;
      while (n < 225) begin
        k = $urandom_range(99);
        // few rows so slots fill; occasionally any row
        row = ($urandom_range(7) == 0) ? 10'($urandom) : 10'($urandom_range(3));
        if (k < 55) op = OP_INSERT;
        else if (k < 88) op = OP_QUERY;
        else if (k < 96) op = OP_EOW;
        else op = OP_NOP;
        issue(op, row, pick_key(), 0, dummy);
        n++;
      end
      drain();
    end

    // Saturation is unreachable in a short run; counts stay small by design
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
